FILE: rtl/pgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_pkg
// Shared types and constants for the parking gate controller core.
// ----------------------------------------------------------------------------
package pgc_pkg;

  localparam int SPACE_SENSORS  = 3;
  localparam int DEFAULT_SPACES = 3;
  localparam int SECOND_TICKS   = 20;

  localparam int PHASE_W = $clog2(SECOND_TICKS);
  localparam int SPACE_W = 4;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] KEY_IDLE  = 3'd0;
  localparam logic [2:0] KEY_MODE  = 3'd1;
  localparam logic [2:0] KEY_ENTRY = 3'd2;
  localparam logic [2:0] KEY_EXIT  = 3'd3;
  localparam logic [2:0] KEY_EMERG = 3'd4;
  localparam logic [2:0] KEY_SETUP = 3'd5;
  localparam logic [2:0] KEY_ADD   = 3'd6;
  localparam logic [2:0] KEY_SUB   = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_CLOSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPACES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACES = 2'd3;

  typedef struct packed {
    logic [2:0]               key_code;
    logic [SPACE_SENSORS-1:0] space_levels;
    logic                     entry_level;
    logic                     exit_level;
  } pgc_in_t;

  typedef struct packed {
    logic               entry_gate_open;
    logic               exit_gate_open;
    logic [SPACE_W-1:0] free_count;
    logic [SPACE_W-1:0] total_count;
    logic               auto_mode;
    logic               emergency_on;
    logic               menu_on;
    logic               full_alarm;
    logic [1:0]         beep_count;
    logic [1:0]         full_warning_count;
  } pgc_out_t;

  typedef struct packed {
    logic [7:0]         gate_close_seconds;
    logic [7:0]         debounce_threshold;
    logic [SPACE_W-1:0] max_spaces;
    logic [SPACE_W-1:0] min_spaces;
  } pgc_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]       tick_phase;
    logic                     mode_auto;
    logic                     emergency_flag;
    logic                     menu_flag;
    logic                     alarm_latch;
    logic                     entry_gate;
    logic                     exit_gate;
    logic [SPACE_W-1:0]       total_now;
    logic [SPACE_W-1:0]       free_now;
    logic [SPACE_SENSORS-1:0] occupancy;
    logic [7:0]               entry_polls;
    logic [7:0]               exit_polls;
    logic                     entry_trigger;
    logic                     exit_trigger;
    logic [7:0]               entry_close;
    logic [7:0]               exit_close;
  } pgc_state_t;

endpackage

FILE: rtl/parking_gate_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parking_gate_controller_core
// Parking lot gate controller, one loop tick per request.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one request per loop tick,
// carrying the key code and the raw active-low space, entry and exit sensors.
// Output channel (out_valid / out_stall / out_data): one result per request
// with gate states, free and total counts, mode flags and the beep and
// full-warning counts for that tick.
// Config port (cfg_write / cfg_index / cfg_data): write only while idle.
// A request moves from the input register into the result register.
// Throughput: one request per cycle unless the receiver stalls; the input
// register feeds the step logic and the result register in a single pass,
// and controller state updates as the request enters the result register.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and then in_stall rises.
// Reset clears both stages and returns all controller state and config
// registers to their defaults.
// ----------------------------------------------------------------------------
module parking_gate_controller_core
  import pgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pgc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pgc_out_t             out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pgc_cfg_t   cfg;
  pgc_state_t state;
  pgc_state_t state_next;
  pgc_out_t   result;
  pgc_in_t    item;
  logic       item_valid;
  logic       advance;

  pgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pgc_step u_step (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.tick_phase     <= '0;
      state.mode_auto      <= 1'b1;
      state.emergency_flag <= 1'b0;
      state.menu_flag      <= 1'b0;
      state.alarm_latch    <= 1'b0;
      state.entry_gate     <= 1'b0;
      state.exit_gate      <= 1'b0;
      state.total_now      <= SPACE_W'(DEFAULT_SPACES);
      state.free_now       <= SPACE_W'(DEFAULT_SPACES);
      state.occupancy      <= '0;
      state.entry_polls    <= 8'd0;
      state.exit_polls     <= 8'd0;
      state.entry_trigger  <= 1'b0;
      state.exit_trigger   <= 1'b0;
      state.entry_close    <= 8'd0;
      state.exit_close     <= 8'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  a_held_item_stable: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !advance) |=> (item_valid && $stable(item)))
    else $error("pending request lost or changed");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("controller state changed without a request");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    state.tick_phase < PHASE_W'(SECOND_TICKS))
    else $error("tick phase out of range");

endmodule

FILE: rtl/pgc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_cfg_regs
// Configuration register file: gate close time, debounce and space limits.
// ----------------------------------------------------------------------------
module pgc_cfg_regs
  import pgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output pgc_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_close_seconds <= 8'd5;
      cfg.debounce_threshold <= 8'd5;
      cfg.max_spaces         <= 4'd8;
      cfg.min_spaces         <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GATE_CLOSE: cfg.gate_close_seconds <= cfg_data;
        CFG_DEBOUNCE:   cfg.debounce_threshold <= cfg_data;
        CFG_MAX_SPACES: cfg.max_spaces         <= cfg_data[SPACE_W-1:0];
        CFG_MIN_SPACES: cfg.min_spaces         <= cfg_data[SPACE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/pgc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_step
// Next-state and result logic for one loop tick: keys, sensor poll,
// auto close and the once-per-second close timer countdown.
// ----------------------------------------------------------------------------
module pgc_step
  import pgc_pkg::*;
(
  input  pgc_in_t    item,
  input  pgc_state_t state,
  input  pgc_cfg_t   cfg,
  output pgc_state_t state_next,
  output pgc_out_t   result
);

  function automatic logic [SPACE_W-1:0] free_calc(
    input logic [SPACE_W-1:0]       total,
    input logic [SPACE_SENSORS-1:0] occ
  );
    logic [SPACE_W-1:0] n;
    n = '0;
    for (int i = 0; i < SPACE_SENSORS; i++) begin
      n = n + SPACE_W'(occ[i]);
    end
    return (n <= total) ? total - n : '0;
  endfunction

  logic [1:0] beeps;
  logic [1:0] fulls;

  always_comb begin
    state_next = state;
    beeps      = 2'd0;
    fulls      = 2'd0;

    state_next.tick_phase = (state.tick_phase == PHASE_W'(SECOND_TICKS - 1)) ?
                            '0 : state.tick_phase + 1'b1;

    if (item.key_code != KEY_IDLE) begin
      beeps = 2'd1;
    end

    unique case (item.key_code)
      KEY_IDLE: ;
      KEY_MODE: begin
        state_next.mode_auto = !state.mode_auto;
        if (state.mode_auto) begin
          state_next.entry_gate = 1'b0;
          state_next.exit_gate  = 1'b0;
        end
      end
      KEY_ENTRY: begin
        if (!state.mode_auto) begin
          state_next.entry_gate  = !state.entry_gate;
          state_next.entry_close = state.entry_gate ? 8'd0 : cfg.gate_close_seconds;
        end
      end
      KEY_EXIT: begin
        if (!state.mode_auto) begin
          state_next.exit_gate  = !state.exit_gate;
          state_next.exit_close = state.exit_gate ? 8'd0 : cfg.gate_close_seconds;
        end
      end
      KEY_EMERG: begin
        state_next.emergency_flag = !state.emergency_flag;
        if (!state.emergency_flag) begin
          state_next.entry_gate = 1'b1;
          state_next.exit_gate  = 1'b1;
        end
      end
      KEY_SETUP: begin
        state_next.menu_flag = !state.menu_flag;
        if (state.menu_flag) begin
          state_next.free_now = free_calc(state.total_now, state.occupancy);
        end
      end
      KEY_ADD: begin
        if (state.menu_flag && state.total_now < cfg.max_spaces) begin
          state_next.total_now = state.total_now + 1'b1;
          if (state.free_now != '1) begin
            state_next.free_now = state.free_now + 1'b1;
          end
        end
      end
      KEY_SUB: begin
        if (state.menu_flag && state.total_now > cfg.min_spaces) begin
          state_next.total_now = state.total_now - 1'b1;
          if (state.free_now != '0) begin
            state_next.free_now = state.free_now - 1'b1;
          end
        end
      end
      default: ;
    endcase

    // sensor poll, every 4th tick
    if (state_next.tick_phase[1:0] == 2'b00) begin
      state_next.occupancy = ~item.space_levels;
      state_next.free_now  = free_calc(state_next.total_now, ~item.space_levels);

      if (state_next.free_now == '0 && !state_next.alarm_latch) begin
        state_next.alarm_latch = 1'b1;
        fulls = fulls + 2'd1;
      end else if (state_next.free_now != '0) begin
        state_next.alarm_latch = 1'b0;
      end

      if (state_next.mode_auto && !state_next.emergency_flag) begin
        if (!item.entry_level) begin
          if (state_next.entry_polls != 8'hFF) begin
            state_next.entry_polls = state_next.entry_polls + 8'd1;
          end
          if (state_next.entry_polls >= cfg.debounce_threshold &&
              !state_next.entry_trigger) begin
            state_next.entry_trigger = 1'b1;
            if (state_next.free_now != '0 && !state_next.entry_gate) begin
              state_next.entry_gate  = 1'b1;
              state_next.entry_close = cfg.gate_close_seconds;
              beeps = beeps + 2'd1;
            end else if (state_next.free_now == '0) begin
              fulls = fulls + 2'd1;
            end
          end
        end else begin
          state_next.entry_polls   = 8'd0;
          state_next.entry_trigger = 1'b0;
        end

        if (!item.exit_level) begin
          if (state_next.exit_polls != 8'hFF) begin
            state_next.exit_polls = state_next.exit_polls + 8'd1;
          end
          if (state_next.exit_polls >= cfg.debounce_threshold &&
              !state_next.exit_trigger) begin
            state_next.exit_trigger = 1'b1;
            if (!state_next.exit_gate) begin
              state_next.exit_gate  = 1'b1;
              state_next.exit_close = cfg.gate_close_seconds;
              beeps = beeps + 2'd1;
            end
          end
        end else begin
          state_next.exit_polls   = 8'd0;
          state_next.exit_trigger = 1'b0;
        end
      end
    end

    // auto close, every 2nd tick
    if (!state_next.tick_phase[0] && !state_next.emergency_flag) begin
      if (state_next.entry_gate && state_next.entry_close == 8'd0) begin
        state_next.entry_gate = 1'b0;
      end
      if (state_next.exit_gate && state_next.exit_close == 8'd0) begin
        state_next.exit_gate = 1'b0;
      end
    end

    // close timers, once per second
    if (state_next.tick_phase == '0) begin
      if (state_next.entry_close != 8'd0) begin
        state_next.entry_close = state_next.entry_close - 8'd1;
      end
      if (state_next.exit_close != 8'd0) begin
        state_next.exit_close = state_next.exit_close - 8'd1;
      end
    end
  end

  always_comb begin
    result.entry_gate_open    = state_next.entry_gate;
    result.exit_gate_open     = state_next.exit_gate;
    result.free_count         = state_next.free_now;
    result.total_count        = state_next.total_now;
    result.auto_mode          = state_next.mode_auto;
    result.emergency_on       = state_next.emergency_flag;
    result.menu_on            = state_next.menu_flag;
    result.full_alarm         = state_next.alarm_latch;
    result.beep_count         = beeps;
    result.full_warning_count = fulls;
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for parking_gate_controller_core.
// ----------------------------------------------------------------------------
// A per-request model of the lot controller predicts every result. Traffic is
// built as short episodes: cars waiting at the entry or exit, menu sessions,
// manual gate handling, emergency passes, quiet stretches and random noise.
// These run under several register settings, including the extremes. Both
// handshakes idle in random bursts, and once the receiver holds off long
// enough to back the core up.
// ----------------------------------------------------------------------------
module tb;
  import pgc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pgc_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pgc_out_t             out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  parking_gate_controller_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  typedef struct {
    int unsigned phase;
    bit          auto_on, emerg, menu, alarm, entry_open, exit_open;
    logic [3:0]  total, free_sp;
    logic [2:0]  occ;
    logic [7:0]  entry_deb, exit_deb, entry_close, exit_close;
    bit          entry_trig, exit_trig;
  } lot_t;

  lot_t       lot;
  logic [7:0] reg_gate = 8'd5, reg_debounce = 8'd5;
  logic [3:0] reg_max = 4'd8, reg_min = 4'd1;

  pgc_in_t  pending_reqs[$];
  pgc_out_t lot_expect[$];
  logic [2:0] sensor_lv = 3'b111;
  bit  calm = 1'b0, hold_off = 1'b0, req_taken = 1'b0;
  int  send_gap = 0, stall_left = 0;
  int  n_queued = 0, n_taken = 0, n_checked = 0, n_errors = 0, n_settings = 1;

  function automatic logic [3:0] free_after_occ();
    int n;
    n = $countones(lot.occ);
    return (n <= lot.total) ? lot.total - 4'(n) : 4'd0;
  endfunction

  function automatic pgc_out_t step_lot(pgc_in_t req);
    pgc_out_t r;
    int beeps, warns;
    beeps = 0;
    warns = 0;
    lot.phase = (lot.phase + 1 >= SECOND_TICKS) ? 0 : lot.phase + 1;

    if (req.key_code != KEY_IDLE) begin
      beeps++;
      case (req.key_code)
        KEY_MODE: begin
          lot.auto_on = !lot.auto_on;
          if (!lot.auto_on) begin
            lot.entry_open = 1'b0;
            lot.exit_open = 1'b0;
          end
        end
        KEY_ENTRY: if (!lot.auto_on) begin
          lot.entry_open = !lot.entry_open;
          lot.entry_close = lot.entry_open ? reg_gate : 8'd0;
        end
        KEY_EXIT: if (!lot.auto_on) begin
          lot.exit_open = !lot.exit_open;
          lot.exit_close = lot.exit_open ? reg_gate : 8'd0;
        end
        KEY_EMERG: begin
          lot.emerg = !lot.emerg;
          if (lot.emerg) begin
            lot.entry_open = 1'b1;
            lot.exit_open = 1'b1;
          end
        end
        KEY_SETUP: begin
          lot.menu = !lot.menu;
          if (!lot.menu) lot.free_sp = free_after_occ();
        end
        KEY_ADD: if (lot.menu && lot.total < reg_max) begin
          lot.total++;
          if (lot.free_sp < 4'd15) lot.free_sp++;
        end
        KEY_SUB: if (lot.menu && lot.total > reg_min) begin
          lot.total--;
          if (lot.free_sp > 4'd0) lot.free_sp--;
        end
        default: ;
      endcase
    end

    if (lot.phase % 4 == 0) begin
      lot.occ = ~req.space_levels;
      lot.free_sp = free_after_occ();
      if (lot.free_sp == 4'd0 && !lot.alarm) begin
        lot.alarm = 1'b1;
        warns++;
      end else if (lot.free_sp > 4'd0) begin
        lot.alarm = 1'b0;
      end
      if (lot.auto_on && !lot.emerg) begin
        if (!req.entry_level) begin
          if (lot.entry_deb != 8'hFF) lot.entry_deb++;
          if (lot.entry_deb >= reg_debounce && !lot.entry_trig) begin
            lot.entry_trig = 1'b1;
            if (lot.free_sp > 4'd0 && !lot.entry_open) begin
              lot.entry_open = 1'b1;
              lot.entry_close = reg_gate;
              beeps++;
            end else if (lot.free_sp == 4'd0) begin
              warns++;
            end
          end
        end else begin
          lot.entry_deb = 8'd0;
          lot.entry_trig = 1'b0;
        end
        if (!req.exit_level) begin
          if (lot.exit_deb != 8'hFF) lot.exit_deb++;
          if (lot.exit_deb >= reg_debounce && !lot.exit_trig) begin
            lot.exit_trig = 1'b1;
            if (!lot.exit_open) begin
              lot.exit_open = 1'b1;
              lot.exit_close = reg_gate;
              beeps++;
            end
          end
        end else begin
          lot.exit_deb = 8'd0;
          lot.exit_trig = 1'b0;
        end
      end
    end

    if (lot.phase % 2 == 0 && !lot.emerg) begin
      if (lot.entry_open && lot.entry_close == 8'd0) lot.entry_open = 1'b0;
      if (lot.exit_open && lot.exit_close == 8'd0) lot.exit_open = 1'b0;
    end

    if (lot.phase == 0) begin
      if (lot.entry_close != 8'd0) lot.entry_close--;
      if (lot.exit_close != 8'd0) lot.exit_close--;
    end

    r.entry_gate_open    = lot.entry_open;
    r.exit_gate_open     = lot.exit_open;
    r.free_count         = lot.free_sp;
    r.total_count        = lot.total;
    r.auto_mode          = lot.auto_on;
    r.emergency_on       = lot.emerg;
    r.menu_on            = lot.menu;
    r.full_alarm         = lot.alarm;
    r.beep_count         = beeps[1:0];
    r.full_warning_count = warns[1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // monitor: checks accepted results, predicts accepted requests
  always @(posedge clk) begin : monitor
    pgc_out_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lot_expect.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = lot_expect.pop_front();
          if (out_data !== want)
            report_mismatch($sformatf("result %0d: got %p, expected %p",
                                      n_checked, out_data, want));
          n_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        lot_expect.push_back(step_lot(in_data));
        n_taken++;
      end
      req_taken <= in_valid && !in_stall;
    end
  end

  // driver: request side
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // long receiver hold-off so the core fills and stalls its input
  initial begin
    while (n_taken < 300) @(posedge clk);
    hold_off = 1'b1;
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2000000;
    $display("Timeout: %0d of %0d requests checked", n_checked, n_queued);
    $display("Verification failed");
    $finish;
  end

  task automatic queue_tick(logic [2:0] key, logic [2:0] lv, logic en, logic ex);
    pgc_in_t req;
    req.key_code = key;
    req.space_levels = lv;
    req.entry_level = en;
    req.exit_level = ex;
    pending_reqs.push_back(req);
    n_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_GATE_CLOSE: reg_gate = val;
      CFG_DEBOUNCE:   reg_debounce = val;
      CFG_MAX_SPACES: reg_max = val[3:0];
      CFG_MIN_SPACES: reg_min = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_limits(logic [7:0] gate, logic [7:0] deb, logic [3:0] mx,
                            logic [3:0] mn);
    write_reg(CFG_GATE_CLOSE, gate);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_MAX_SPACES, {4'd0, mx});
    write_reg(CFG_MIN_SPACES, {4'd0, mn});
    n_settings++;
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid || lot_expect.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_directed();
    queue_tick(KEY_IDLE, 3'b111, 1'b1, 1'b1);
    queue_tick(KEY_MODE, 3'b111, 1'b1, 1'b1);
    queue_tick(KEY_ENTRY, 3'b111, 1'b1, 1'b1);
    queue_tick(KEY_EXIT, 3'b000, 1'b0, 1'b0);
    queue_tick(KEY_ENTRY, 3'b000, 1'b0, 1'b0);
    queue_tick(KEY_EXIT, 3'b111, 1'b1, 1'b1);
    queue_tick(KEY_MODE, 3'b111, 1'b1, 1'b1);
    queue_tick(KEY_EMERG, 3'b000, 1'b0, 1'b0);
    queue_tick(KEY_IDLE, 3'b000, 1'b0, 1'b0);
    queue_tick(KEY_EMERG, 3'b111, 1'b1, 1'b1);
    queue_tick(KEY_SETUP, 3'b111, 1'b1, 1'b1);
    repeat (6) queue_tick(KEY_ADD, 3'b111, 1'b1, 1'b1);
    queue_tick(KEY_SUB, 3'b111, 1'b1, 1'b1);
    queue_tick(KEY_SETUP, 3'b000, 1'b1, 1'b1);
    repeat (6) queue_tick(KEY_IDLE, 3'b010, 1'b0, 1'b0);
  endtask

  task automatic queue_traffic(int unsigned n);
    int unsigned goal, kind, len;
    logic [2:0] key;
    goal = n_queued + n;
    while (n_queued < goal) begin
      if ($urandom_range(0, 2) == 0) sensor_lv = 3'($urandom);
      kind = $urandom_range(0, 99);
      len = 4 * ((reg_debounce > 8'd12) ? 12 : reg_debounce) + $urandom_range(1, 12);
      if (kind < 35) begin
        repeat (len) queue_tick(KEY_IDLE, sensor_lv, 1'b0, $urandom_range(0, 5) != 0);
      end else if (kind < 55) begin
        repeat (len) queue_tick(KEY_IDLE, sensor_lv, 1'b1, 1'b0);
      end else if (kind < 63) begin
        repeat (len) queue_tick(KEY_IDLE, sensor_lv, 1'b0, 1'b0);
      end else if (kind < 73) begin
        key = $urandom_range(0, 1) ? KEY_ADD : KEY_SUB;
        queue_tick(KEY_SETUP, sensor_lv, 1'b1, 1'b1);
        repeat ($urandom_range(1, 10))
          queue_tick($urandom_range(0, 3) != 0 ? key : KEY_IDLE, sensor_lv, 1'b1, 1'b1);
        queue_tick(KEY_SETUP, sensor_lv, 1'b1, 1'b1);
      end else if (kind < 81) begin
        queue_tick(KEY_MODE, sensor_lv, 1'b1, 1'b1);
        repeat ($urandom_range(1, 12)) begin
          key = $urandom_range(0, 1) ? KEY_ENTRY : KEY_EXIT;
          queue_tick($urandom_range(0, 2) == 0 ? KEY_IDLE : key, sensor_lv,
                     1'($urandom), 1'($urandom));
        end
        queue_tick(KEY_MODE, sensor_lv, 1'b1, 1'b1);
      end else if (kind < 87) begin
        queue_tick(KEY_EMERG, sensor_lv, 1'b1, 1'b1);
        repeat ($urandom_range(1, 10))
          queue_tick(KEY_IDLE, 3'($urandom), 1'($urandom), 1'($urandom));
        queue_tick(KEY_EMERG, sensor_lv, 1'b1, 1'b1);
      end else if (kind < 93) begin
        repeat ($urandom_range(1, 40)) queue_tick(KEY_IDLE, sensor_lv, 1'b1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          queue_tick(3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    lot = '{phase: 0, auto_on: 1'b1, total: 4'(DEFAULT_SPACES),
            free_sp: 4'(DEFAULT_SPACES), default: '0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_directed();
    settle();
    set_limits(8'd0, 8'd0, 4'd15, 4'd0);
    queue_traffic(150);
    settle();
    set_limits(8'($urandom_range(1, 3)), 8'd1, 4'd4, 4'd2);
    queue_traffic(170);
    settle();
    set_limits(8'd255, 8'd255, 4'd1, 4'd8);
    queue_traffic(40);
    settle();
    calm = 1'b1;
    set_limits(8'd5, 8'd5, 4'd8, 4'd1);
    queue_traffic(200);

    while (pending_reqs.size() != 0 || in_valid || lot_expect.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Summary: %0d requests, %0d results checked under %0d register settings",
             n_taken, n_checked, n_settings);
    $display("Traffic: cars at both gates, menu limits, manual and emergency use, noise");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
